/* sv/fdcp_pkg.sv */
// Shared types and constants for the floppy disk controller port block.
// No dependencies; every other file imports this package.
package fdcp_pkg;

    localparam int DRIVES_DEF = 4;
    localparam int TRACKS_DEF = 77;
    localparam int SECTORS    = 32;
    localparam int SECTOR_LEN = 137;
    localparam int BUF_LEN    = SECTOR_LEN + 1;
    localparam int BUF_AW     = $clog2(BUF_LEN);

    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int DRV_W   = 4;
    localparam int ADDR_W  = 19;
    localparam int TRACK_W = 7;
    localparam int SEC_W   = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ    = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_MOUNT   = 3'd2,
        CMD_LOAD    = 3'd3,
        CMD_UNMOUNT = 3'd4
    } t_cmd;

    localparam logic [BYTE_W-1:0] PORT_STAT = 8'h08;
    localparam logic [BYTE_W-1:0] PORT_SECT = 8'h09;
    localparam logic [BYTE_W-1:0] PORT_DATA = 8'h0A;

    localparam logic [SEC_W-1:0]  NO_SECTOR = 6'h3F;
    localparam logic [BYTE_W-1:0] BUF_EMPTY = 8'hFF;

    // status bits
    localparam logic [BYTE_W-1:0] ST_WREN   = 8'h01;
    localparam logic [BYTE_W-1:0] ST_TRK0   = 8'h40;
    localparam logic [BYTE_W-1:0] ST_HEAD   = 8'h84;
    localparam logic [BYTE_W-1:0] ST_SELECT = 8'h1A;
    localparam logic [BYTE_W-1:0] ST_HLOAD  = 8'h04;

endpackage

/* sv/fdcp_if.sv */
// Valid/ready channel interfaces for the controller's input and result streams.
// Depends on fdcp_pkg for field widths.
interface fdcp_in_if import fdcp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [BYTE_W-1:0]   port;
    logic [BYTE_W-1:0]   byte_value;
    logic [DRV_W-1:0]    drive;
    logic [ADDR_W-1:0]   image_address;

    modport source (output valid, command, port, byte_value, drive, image_address,
                    input ready);
    modport sink   (input valid, command, port, byte_value, drive, image_address,
                    output ready);
endinterface

interface fdcp_out_if import fdcp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

/* sv/floppy_disk_controller_ports.sv */
// Top level of the floppy disk controller port block: command sequencer,
// drive state registers, image store and sector buffer.
// Depends on fdcp_pkg, fdcp_if, fdcp_image_mem and fdcp_sector_buf.
//
// One command is taken at a time and gives exactly one result transfer on
// o_out (read_data, zero for anything but a port read). A data-port read
// with an empty buffer fills the sector buffer from the image store, one
// byte a cycle over the single image read port. A command that must first
// flush a pending sector (a select or function write, a sector-port read, or
// the data write past the last byte) sweeps the 138-byte buffer once through
// its read port and writes the image behind it. The next command is accepted
// once the sequencer is idle, even while the previous result still waits in
// the output register. The image store is not cleared by reset; the host
// loads every byte with load commands, and a read of an image byte never
// loaded returns an unspecified value. There is no clearing pass: the block
// accepts commands from the first cycle after reset.
module floppy_disk_controller_ports import fdcp_pkg::*; #(
    parameter int DRIVES = DRIVES_DEF,
    parameter int TRACKS = TRACKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fdcp_in_if.sink     i_in,
    fdcp_out_if.source  o_out
);
    localparam int IMAGE_SIZE = TRACKS * SECTORS * SECTOR_LEN;
    localparam int DEPTH      = DRIVES * IMAGE_SIZE;
    localparam int AW         = $clog2(DEPTH);
    localparam int DW         = (DRIVES > 1) ? $clog2(DRIVES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_BRD, S_BASE, S_FILL, S_FBASE, S_FLUSH, S_POST, S_DONE
    } t_state;

    t_state             r_st;
    logic [CMD_W-1:0]   r_cmd;
    logic [BYTE_W-1:0]  r_port;
    logic [BYTE_W-1:0]  r_val;
    logic [DRV_W-1:0]   r_drv;
    logic [ADDR_W-1:0]  r_addr;

    logic [TRACK_W-1:0] r_track [DRIVES];
    logic [DRIVES-1:0]  r_mnt;
    logic               r_selv;
    logic [DRV_W-1:0]   r_seln;
    logic [BYTE_W-1:0]  r_stat;
    logic [SEC_W-1:0]   r_sec;
    logic [BYTE_W-1:0]  r_bp;
    logic               r_wp;

    logic [BYTE_W-1:0]  r_res;
    logic [BYTE_W-1:0]  r_idx;
    logic [AW-1:0]      r_base;
    logic               r_ok;
    logic               r_pz;
    logic               r_outv;
    logic [BYTE_W-1:0]  r_outd;

    // memory ports
    logic               img_we;
    logic [AW-1:0]      img_waddr, img_raddr, load_addr;
    logic [BYTE_W-1:0]  img_wdata, img_rdata;
    logic               buf_we;
    logic [BUF_AW-1:0]  buf_waddr, buf_raddr;
    logic [BYTE_W-1:0]  buf_wdata, buf_rdata;

    // decode helpers
    logic               is_rd, is_wr, drv_in, sel_in, load_ok;
    logic [DW-1:0]      sel_idx, drv_idx, post_idx;
    logic               post_in;
    logic [TRACK_W-1:0] sel_trk, post_trk, t1, t2;
    logic [11:0]        ts;
    logic [AW-1:0]      base_c;
    logic               ok_c;
    logic [SEC_W:0]     sec_inc;
    logic [BYTE_W-1:0]  s9;

    assign is_rd   = (r_cmd == CMD_READ);
    assign is_wr   = (r_cmd == CMD_WRITE);
    assign drv_in  = ({1'b0, r_drv} < 5'(DRIVES));
    assign sel_in  = ({1'b0, r_seln} < 5'(DRIVES));
    assign drv_idx = r_drv[DW-1:0];
    assign sel_idx = r_seln[DW-1:0];
    assign load_ok = drv_in && ({1'b0, r_addr} < 20'(IMAGE_SIZE));
    assign load_addr = AW'(drv_idx) * AW'(IMAGE_SIZE) + AW'(r_addr);
    assign sel_trk = sel_in ? r_track[sel_idx] : '0;

    // image base of the selected drive, head track and sector
    assign ok_c   = sel_in && r_mnt[sel_idx] && ({1'b0, sel_trk} < 8'(TRACKS))
                    && (r_sec < 6'(SECTORS));
    assign ts     = {sel_trk, r_sec[4:0]};
    assign base_c = ok_c ? (AW'(sel_idx) * AW'(IMAGE_SIZE) + AW'(ts) * AW'(SECTOR_LEN))
                         : '0;

    // post-flush track lookup: new selection for a select write, else current
    assign post_idx = (r_port == PORT_STAT) ? r_val[DW-1:0] : sel_idx;
    assign post_in  = (r_port == PORT_STAT) ? ({1'b0, r_val[3:0]} < 5'(DRIVES)) : sel_in;
    assign post_trk = post_in ? r_track[post_idx] : '0;

    // head stepping: step in, then step out, clamped at both ends
    assign t1 = (r_val[0] && post_in && ({1'b0, post_trk} < 8'(TRACKS - 1)))
                ? post_trk + 7'd1 : post_trk;
    assign t2 = (r_val[1] && post_in && (t1 != '0)) ? t1 - 7'd1 : t1;

    always_comb begin
        s9 = (t2 == '0) ? (r_stat | ST_TRK0) : (r_stat & ~ST_TRK0);
        if (r_val[2]) s9 = s9 | ST_HEAD;
        if (r_val[3]) s9 = s9 & ~ST_HEAD;
        if (r_val[7]) s9 = s9 | ST_WREN;
    end

    assign sec_inc = {1'b0, r_sec} + 7'd1;

    // image write: load command, or flush copy trailing the registered buffer read
    assign img_we    = ((r_st == S_DEC) && (r_cmd == CMD_LOAD) && load_ok) ||
                       ((r_st == S_FLUSH) && (r_idx != '0) && r_ok);
    assign img_waddr = (r_st == S_FLUSH) ? r_base + AW'(r_idx - 8'd1) : load_addr;
    assign img_wdata = (r_st == S_FLUSH) ? (r_pz ? '0 : buf_rdata) : r_val;
    assign img_raddr = r_base + AW'(r_idx);

    assign buf_raddr = (r_st == S_DEC) ? r_bp[BUF_AW-1:0] : r_idx[BUF_AW-1:0];

    always_comb begin
        buf_we    = 1'b0;
        buf_waddr = r_idx[BUF_AW-1:0];
        buf_wdata = '0;
        case (r_st)
            S_DEC: begin
                // a data write lands in the buffer whenever the position is live,
                // the spare last byte included
                buf_we    = is_wr && (r_port == PORT_DATA) && r_selv &&
                            (r_bp < 8'(BUF_LEN));
                buf_waddr = r_bp[BUF_AW-1:0];
                buf_wdata = r_val;
            end
            S_FLUSH: begin
                // zero-pad the tail of a partial write
                buf_we = (r_idx >= r_bp);
            end
            S_FILL: begin
                buf_we    = (r_idx != '0);
                buf_waddr = BUF_AW'(r_idx - 8'd1);
                buf_wdata = (r_ok && (r_idx <= 8'(SECTOR_LEN))) ? img_rdata : '0;
            end
            default: ;
        endcase
    end

    fdcp_image_mem #(.DEPTH(DEPTH), .AW(AW)) u_img (
        .i_clk   (i_clk),
        .i_we    (img_we),
        .i_waddr (img_waddr),
        .i_wdata (img_wdata),
        .i_raddr (img_raddr),
        .o_rdata (img_rdata)
    );

    fdcp_sector_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    assign i_in.ready      = (r_st == S_IDLE);
    assign o_out.valid     = r_outv;
    assign o_out.read_data = r_outd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_mnt  <= '0;
            r_selv <= 1'b0;
            r_seln <= '0;
            r_stat <= '0;
            r_sec  <= NO_SECTOR;
            r_bp   <= BUF_EMPTY;
            r_wp   <= 1'b0;
            r_outv <= 1'b0;
            r_idx  <= '0;
            for (int d = 0; d < DRIVES; d++) r_track[d] <= '0;
        end else begin
            // drop the result once taken; S_DONE handles its own refill
            if (r_outv && o_out.ready && (r_st != S_DONE)) r_outv <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd  <= i_in.command;
                        r_port <= i_in.port;
                        r_val  <= i_in.byte_value;
                        r_drv  <= i_in.drive;
                        r_addr <= i_in.image_address;
                        r_res  <= '0;
                        r_st   <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_st <= S_DONE;
                    case (r_cmd)
                        CMD_READ: begin
                            if (r_port == PORT_STAT) begin
                                r_res <= r_selv ? ~r_stat : 8'hFF;
                            end else if (r_port == PORT_SECT) begin
                                if (r_wp && r_selv) begin
                                    r_st <= S_FBASE;
                                end else begin
                                    r_wp <= 1'b0;
                                    r_st <= S_POST;
                                end
                            end else if (r_port == PORT_DATA) begin
                                if (!r_selv) r_res <= '0;
                                else if (r_bp < 8'(BUF_LEN)) r_st <= S_BRD;
                                else r_st <= S_BASE;
                            end else begin
                                r_res <= 8'hFF;
                            end
                        end
                        CMD_WRITE: begin
                            if ((r_port == PORT_STAT) ||
                                (r_selv && ((r_port == PORT_SECT) ||
                                 ((r_port == PORT_DATA) && (r_bp > 8'(SECTOR_LEN - 1)))))) begin
                                if (r_wp && r_selv) begin
                                    r_st <= S_FBASE;
                                end else begin
                                    r_wp <= 1'b0;
                                    r_st <= S_POST;
                                end
                            end else if (r_selv && (r_port == PORT_DATA)) begin
                                r_bp <= r_bp + 8'd1;
                                r_wp <= 1'b1;
                            end
                        end
                        CMD_MOUNT: begin
                            if (drv_in) begin
                                r_mnt[drv_idx]   <= 1'b1;
                                r_track[drv_idx] <= '0;
                            end
                        end
                        CMD_UNMOUNT: begin
                            if (drv_in) begin
                                if (r_selv && (r_seln == r_drv)) begin
                                    r_selv <= 1'b0;
                                    r_stat <= '0;
                                end
                                r_mnt[drv_idx]   <= 1'b0;
                                r_track[drv_idx] <= '0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_BRD: begin
                    r_res <= buf_rdata;
                    r_bp  <= r_bp + 8'd1;
                    r_st  <= S_DONE;
                end
                S_BASE: begin
                    r_base <= base_c;
                    r_ok   <= ok_c;
                    r_idx  <= '0;
                    r_st   <= S_FILL;
                end
                S_FILL: begin
                    // read image byte idx, write buffer byte idx-1
                    if (r_idx == 8'd1) r_res <= buf_wdata;
                    if (r_idx == 8'(BUF_LEN)) begin
                        r_bp <= 8'd1;
                        r_st <= S_DONE;
                    end
                    r_idx <= r_idx + 8'd1;
                end
                S_FBASE: begin
                    r_base <= base_c;
                    r_ok   <= ok_c;
                    r_idx  <= '0;
                    r_st   <= S_FLUSH;
                end
                S_FLUSH: begin
                    r_pz  <= (r_idx >= r_bp);
                    r_idx <= r_idx + 8'd1;
                    if (r_idx == 8'(BUF_LEN - 1)) begin
                        r_stat <= r_stat & ~ST_WREN;
                        r_bp   <= BUF_EMPTY;
                        r_wp   <= 1'b0;
                        r_st   <= S_POST;
                    end
                end
                S_POST: begin
                    r_st <= S_DONE;
                    if (is_rd) begin
                        // sector port read: advance the sector counter when selected with the head loaded
                        if (r_selv && ((r_stat & ST_HLOAD) != '0)) begin
                            r_sec <= (sec_inc > 7'(SECTORS - 1)) ? '0 : sec_inc[SEC_W-1:0];
                            r_bp  <= BUF_EMPTY;
                            r_res <= (((sec_inc > 7'(SECTORS - 1)) ? 8'h00
                                       : {sec_inc[6:0], 1'b0}) & 8'h3E) | 8'hC0;
                        end else begin
                            r_res <= '0;
                        end
                    end else if (r_port == PORT_STAT) begin
                        r_seln <= r_val[3:0];
                        r_sec  <= NO_SECTOR;
                        r_bp   <= BUF_EMPTY;
                        if (r_val[7]) begin
                            r_selv <= 1'b0;
                            r_stat <= '0;
                        end else begin
                            r_selv <= 1'b1;
                            r_stat <= (post_trk == '0) ? (ST_SELECT | ST_TRK0) : ST_SELECT;
                        end
                    end else if (r_port == PORT_SECT) begin
                        if (post_in) r_track[post_idx] <= t2;
                        if (r_val[0] || r_val[1] || r_val[3]) begin
                            r_sec <= NO_SECTOR;
                            r_bp  <= BUF_EMPTY;
                        end
                        if (r_val[7]) begin
                            r_bp <= '0;
                            r_wp <= 1'b0;
                        end
                        r_stat <= s9;
                    end
                end
                S_DONE: begin
                    if (!r_outv || o_out.ready) begin
                        r_outd <= r_res;
                        r_outv <= 1'b1;
                        r_st   <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // buffer position is a byte index, one past the end, or empty
    a_bp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bp <= 8'(BUF_LEN)) || (r_bp == BUF_EMPTY))
        else $error("buffer position out of range");

    // a pending write always has a live buffer position
    a_wp_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp |-> (r_bp != BUF_EMPTY))
        else $error("pending write with empty buffer");

    // sector counter is a valid sector or none
    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sec < 6'(SECTORS)) || (r_sec == NO_SECTOR))
        else $error("sector position out of range");

    // image is written only by a load or by a flush copy
    a_img_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        img_we |-> ((r_st == S_FLUSH) || ((r_st == S_DEC) && (r_cmd == CMD_LOAD))))
        else $error("unexpected image write");

    // a result that waits is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outv && !o_out.ready) |=> (r_outv && $stable(r_outd)))
        else $error("pending result lost");

endmodule

/* sv/fdcp_image_mem.sv */
// Image store: one write port, one registered read port.
// Depends on fdcp_pkg.
module fdcp_image_mem import fdcp_pkg::*; #(
    parameter int DEPTH = DRIVES_DEF * TRACKS_DEF * SECTORS * SECTOR_LEN,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/fdcp_sector_buf.sv */
// Sector buffer: 138 bytes, one write port, one registered read port.
// Depends on fdcp_pkg.
module fdcp_sector_buf import fdcp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [BUF_AW-1:0] i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic [BUF_AW-1:0] i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);
    logic [BYTE_W-1:0] r_mem [BUF_LEN];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* verif/tb_fdcp_pkg.sv */
// Codes shared by the controller testbench: port-9 function bits, spare commands, image size.
// Depends on fdcp_pkg.
package tb_fdcp_pkg;
    import fdcp_pkg::*;

    localparam logic [BYTE_W-1:0] P9_STEP_IN     = 8'h01;
    localparam logic [BYTE_W-1:0] P9_STEP_OUT    = 8'h02;
    localparam logic [BYTE_W-1:0] P9_HEAD_LOAD   = 8'h04;
    localparam logic [BYTE_W-1:0] P9_HEAD_UNLOAD = 8'h08;
    localparam logic [BYTE_W-1:0] P9_WRITE       = 8'h80;
    localparam logic [BYTE_W-1:0] SEL_DESELECT   = 8'h80;

    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    localparam int IMAGE_SIZE = TRACKS_DEF * SECTORS * SECTOR_LEN;
endpackage

/* verif/fdcp_read_data_checker.sv */
// Predicts read_data for every accepted command and compares it with each result transfer.
// Depends on fdcp_pkg, tb_fdcp_pkg and the channel interfaces in fdcp_if.
module fdcp_read_data_checker import fdcp_pkg::*, tb_fdcp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    fdcp_in_if   in_ch,
    fdcp_out_if  out_ch,
    output int   o_fails,
    output int   o_pending
);
    bit [7:0]         image_mem [DRIVES_DEF*IMAGE_SIZE];
    bit [TRACK_W-1:0] trk [DRIVES_DEF];
    bit               mounted [DRIVES_DEF];
    bit               sel_v;
    bit [DRV_W-1:0]   sel_n;
    bit [7:0]         status;
    bit [SEC_W-1:0]   sec;
    bit [7:0]         bpos;
    bit               wpend;
    bit [7:0]         sbuf [BUF_LEN];

    logic [7:0] read_data_due [$];
    logic [7:0] oldest;

    function automatic bit image_ok(bit [DRV_W-1:0] d);
        return d < DRIVES_DEF && mounted[d] && trk[d] < TRACKS_DEF && sec < SECTORS;
    endfunction

    function automatic int image_base(bit [DRV_W-1:0] d);
        return d * IMAGE_SIZE + (int'(trk[d]) * SECTORS + int'(sec)) * SECTOR_LEN;
    endfunction

    function automatic void flush_sector();
        int b;
        if (!wpend || !sel_v) begin
            wpend = 0;
            return;
        end
        for (int i = bpos; i < BUF_LEN; i++) sbuf[i] = 0;
        if (image_ok(sel_n)) begin
            b = image_base(sel_n);
            for (int i = 0; i < SECTOR_LEN; i++) image_mem[b+i] = sbuf[i];
        end
        status &= ~ST_WREN;
        bpos = BUF_EMPTY;
        wpend = 0;
    endfunction

    function automatic logic [7:0] port_read(logic [7:0] p);
        logic [7:0] r;
        int b;
        case (p)
            PORT_STAT: return sel_v ? ~status : 8'hFF;
            PORT_SECT: begin
                flush_sector();
                if (!sel_v || (status & ST_HLOAD) == 0) return 8'h00;
                sec = sec + 1;
                if (sec > SECTORS - 1) sec = 0;
                bpos = BUF_EMPTY;
                return {2'b11, sec[4:0], 1'b0};
            end
            PORT_DATA: begin
                if (!sel_v) return 8'h00;
                if (bpos < BUF_LEN) begin
                    r = sbuf[bpos];
                    bpos++;
                    return r;
                end
                foreach (sbuf[i]) sbuf[i] = 0;
                if (image_ok(sel_n)) begin
                    b = image_base(sel_n);
                    for (int i = 0; i < SECTOR_LEN; i++) sbuf[i] = image_mem[b+i];
                end
                bpos = 1;
                return sbuf[0];
            end
            default: return 8'hFF;
        endcase
    endfunction

    function automatic void port_write(logic [7:0] p, logic [7:0] v);
        bit [DRV_W-1:0] d;
        case (p)
            PORT_STAT: begin
                flush_sector();
                sel_n = v[3:0];
                sec = NO_SECTOR;
                bpos = BUF_EMPTY;
                if (v & SEL_DESELECT) begin
                    sel_v = 0;
                    status = 0;
                end else begin
                    sel_v = 1;
                    status = ST_SELECT;
                    if (sel_n >= DRIVES_DEF || trk[sel_n] == 0) status |= ST_TRK0;
                end
            end
            PORT_SECT: begin
                if (!sel_v) return;
                flush_sector();
                d = sel_n;
                if (v & P9_STEP_IN) begin
                    if (d < DRIVES_DEF && trk[d] < TRACKS_DEF - 1) trk[d]++;
                    sec = NO_SECTOR;
                    bpos = BUF_EMPTY;
                end
                if (v & P9_STEP_OUT) begin
                    if (d < DRIVES_DEF && trk[d] > 0) trk[d]--;
                    sec = NO_SECTOR;
                    bpos = BUF_EMPTY;
                end
                if (d >= DRIVES_DEF || trk[d] == 0) status |= ST_TRK0;
                else status &= ~ST_TRK0;
                if (v & P9_HEAD_LOAD) status |= ST_HEAD;
                if (v & P9_HEAD_UNLOAD) begin
                    status &= ~ST_HEAD;
                    sec = NO_SECTOR;
                    bpos = BUF_EMPTY;
                end
                if (v & P9_WRITE) begin
                    bpos = 0;
                    wpend = 0;
                    status |= ST_WREN;
                end
            end
            PORT_DATA: begin
                if (!sel_v) return;
                if (bpos > SECTOR_LEN - 1) begin
                    if (bpos < BUF_LEN) sbuf[bpos] = v;
                    flush_sector();
                end else begin
                    sbuf[bpos] = v;
                    bpos++;
                    wpend = 1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] controller_step(logic [2:0] c, logic [7:0] p,
                                                   logic [7:0] v, logic [3:0] d,
                                                   logic [18:0] a);
        logic [7:0] r;
        r = 8'h00;
        case (c)
            CMD_READ:  r = port_read(p);
            CMD_WRITE: port_write(p, v);
            CMD_MOUNT: if (d < DRIVES_DEF) begin
                mounted[d] = 1;
                trk[d] = 0;
            end
            CMD_LOAD: if (d < DRIVES_DEF && a < IMAGE_SIZE)
                image_mem[d*IMAGE_SIZE + int'(a)] = v;
            CMD_UNMOUNT: if (d < DRIVES_DEF) begin
                if (sel_v && sel_n == d) begin
                    sel_v = 0;
                    status = 0;
                end
                mounted[d] = 0;
                trk[d] = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (trk[i]) begin
                trk[i] = 0;
                mounted[i] = 0;
            end
            sel_v = 0;
            sel_n = 0;
            status = 0;
            sec = NO_SECTOR;
            bpos = BUF_EMPTY;
            wpend = 0;
            read_data_due.delete();
            o_pending <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                read_data_due.push_back(controller_step(in_ch.command, in_ch.port,
                    in_ch.byte_value, in_ch.drive, in_ch.image_address));
            if (out_ch.valid && out_ch.ready) begin
                if (read_data_due.size() == 0) begin
                    $error("read_data: expected none, actual %02h", out_ch.read_data);
                    o_fails <= o_fails + 1;
                end else begin
                    oldest = read_data_due.pop_front();
                    if (out_ch.read_data !== oldest) begin
                        $error("read_data: expected %02h, actual %02h", oldest,
                               out_ch.read_data);
                        o_fails <= o_fails + 1;
                    end
                end
            end
            o_pending <= read_data_due.size();
        end
    end
endmodule

/* verif/tb_floppy_disk_controller_ports.sv */
// Top of the controller testbench: clock, reset, command stimulus and the verdict.
// Depends on fdcp_pkg, tb_fdcp_pkg, fdcp_if, fdcp_read_data_checker and the block.
module tb_floppy_disk_controller_ports;
    import fdcp_pkg::*;
    import tb_fdcp_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fails;
    int   pending;

    fdcp_in_if  in_ch();
    fdcp_out_if out_ch();

    floppy_disk_controller_ports dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    fdcp_read_data_checker checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .o_fails   (fails),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Stimulus-side view of the drive state. It tracks only what decides which
    // image sector a data-port read may pull in, so that no read ever reaches
    // image bytes that were never loaded or flushed.
    bit               sh_sel_v;
    bit [DRV_W-1:0]   sh_sel_n;
    bit               sh_hl;
    bit [SEC_W-1:0]   sh_sec;
    bit [TRACK_W-1:0] sh_trk [DRIVES_DEF];
    bit               sh_mnt [DRIVES_DEF];
    bit               sector_defined [DRIVES_DEF][TRACKS_DEF][SECTORS];

    bit no_idle;
    int n_items;

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13) return 0;
        if (r < 19) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // A data-port read may fill the buffer from the image; allow it only when
    // that fill yields zeros or hits a sector that holds known bytes.
    function automatic bit data_read_safe();
        if (!sh_sel_v || sh_sel_n >= DRIVES_DEF || !sh_mnt[sh_sel_n] || sh_sec >= SECTORS)
            return 1;
        return sector_defined[sh_sel_n][sh_trk[sh_sel_n]][sh_sec];
    endfunction

    function automatic void track_drive_state(logic [2:0] c, logic [7:0] p,
                                              logic [7:0] v, logic [3:0] d);
        case (c)
            CMD_READ: if (p == PORT_SECT && sh_sel_v && sh_hl)
                sh_sec = (sh_sec >= SECTORS - 1) ? '0 : sh_sec + 1;
            CMD_WRITE: begin
                if (p == PORT_STAT) begin
                    sh_sel_n = v[3:0];
                    sh_sec = NO_SECTOR;
                    sh_sel_v = !(v & SEL_DESELECT);
                    sh_hl = 0;
                end else if (p == PORT_SECT && sh_sel_v) begin
                    if (v & P9_STEP_IN) begin
                        if (sh_sel_n < DRIVES_DEF && sh_trk[sh_sel_n] < TRACKS_DEF - 1)
                            sh_trk[sh_sel_n]++;
                        sh_sec = NO_SECTOR;
                    end
                    if (v & P9_STEP_OUT) begin
                        if (sh_sel_n < DRIVES_DEF && sh_trk[sh_sel_n] > 0)
                            sh_trk[sh_sel_n]--;
                        sh_sec = NO_SECTOR;
                    end
                    if (v & P9_HEAD_LOAD) sh_hl = 1;
                    if (v & P9_HEAD_UNLOAD) begin
                        sh_hl = 0;
                        sh_sec = NO_SECTOR;
                    end
                end
            end
            CMD_MOUNT: if (d < DRIVES_DEF) begin
                sh_mnt[d] = 1;
                sh_trk[d] = 0;
            end
            CMD_UNMOUNT: if (d < DRIVES_DEF) begin
                if (sh_sel_v && sh_sel_n == d) begin
                    sh_sel_v = 0;
                    sh_hl = 0;
                end
                sh_mnt[d] = 0;
                sh_trk[d] = 0;
            end
            default: ;
        endcase
    endfunction

    // Present one command and hold it until the transfer. Keep valid high
    // straight into the next command when no gap is drawn.
    task automatic issue(input logic [2:0] c, input logic [7:0] p, input logic [7:0] v,
                         input logic [3:0] d, input logic [18:0] a);
        int g;
        if (c == CMD_READ && p == PORT_DATA && !data_read_safe()) p = PORT_STAT;
        g = no_idle ? 0 : pick_gap();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.command       <= c;
        in_ch.port          <= p;
        in_ch.byte_value    <= v;
        in_ch.drive         <= d;
        in_ch.image_address <= a;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        track_drive_state(c, p, v, d);
        n_items++;
    endtask

    task automatic port_rd(input logic [7:0] p);
        issue(CMD_READ, p, 8'($urandom), 4'($urandom), 19'($urandom));
    endtask

    task automatic port_wr(input logic [7:0] p, input logic [7:0] v);
        issue(CMD_WRITE, p, v, 4'($urandom), 19'($urandom));
    endtask

    task automatic drive_cmd(input logic [2:0] c, input logic [3:0] d);
        issue(c, 8'($urandom), 8'($urandom), d, 19'($urandom));
    endtask

    // Mount, select, step in to the track, load the head and advance the
    // sector counter until it sits on the wanted sector.
    task automatic seek_sector(input int d, input int t, input int s);
        drive_cmd(CMD_MOUNT, 4'(d));
        port_wr(PORT_STAT, {1'b0, 3'($urandom), 4'(d)});
        repeat (t) port_wr(PORT_SECT, P9_STEP_IN | {1'b0, 3'($urandom), 4'b0});
        port_wr(PORT_SECT, P9_HEAD_LOAD);
        while (sh_sec != s) port_rd(PORT_SECT);
    endtask

    task automatic load_sector(input int d, input int t, input int s);
        for (int i = 0; i < SECTOR_LEN; i++)
            issue(CMD_LOAD, 8'($urandom), 8'($urandom), 4'(d),
                  19'((t * SECTORS + s) * SECTOR_LEN + i));
        sector_defined[d][t][s] = 1;
    endtask

    task automatic read_sector(input int d, input int t, input int s);
        if (!sector_defined[d][t][s]) load_sector(d, t, s);
        seek_sector(d, t, s);
        repeat ($urandom_range(1, 150)) begin
            if ($urandom_range(0, 15) == 0) port_rd(PORT_STAT);
            else port_rd(PORT_DATA);
        end
    endtask

    // Write a full or partial sector, flush it, and sometimes read it back.
    task automatic write_sector(input int d, input int t, input int s);
        int k;
        seek_sector(d, t, s);
        port_wr(PORT_SECT, P9_WRITE);
        k = ($urandom_range(0, 2) == 0) ? $urandom_range(1, SECTOR_LEN) : BUF_LEN;
        repeat (k) port_wr(PORT_DATA, 8'($urandom));
        if (k < BUF_LEN) port_rd(PORT_SECT);
        sector_defined[d][t][s] = 1;
        if ($urandom_range(0, 1)) begin
            port_wr(PORT_SECT, P9_HEAD_UNLOAD);
            port_wr(PORT_SECT, P9_HEAD_LOAD);
            while (sh_sec != s) port_rd(PORT_SECT);
            repeat ($urandom_range(1, 140)) port_rd(PORT_DATA);
        end
    endtask

    // Any command on any port, weighted toward the three live ports.
    task automatic noise_item();
        logic [2:0]  c;
        logic [7:0]  p;
        logic [18:0] a;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c = CMD_READ;
            4, 5, 6:    c = CMD_WRITE;
            7:          c = 3'($urandom_range(CMD_MOUNT, CMD_UNMOUNT));
            8:          c = CMD_LOAD;
            default:    c = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        endcase
        p = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                        : 8'($urandom_range(PORT_STAT, PORT_DATA));
        a = $urandom_range(0, 1) ? 19'($urandom_range(0, IMAGE_SIZE - 1)) : 19'($urandom);
        issue(c, p, 8'($urandom), 4'($urandom), a);
    endtask

    // Drive the head into the outer and inner stops.
    task automatic clamp_run();
        int d;
        d = $urandom_range(0, DRIVES_DEF - 1);
        drive_cmd(CMD_MOUNT, 4'(d));
        port_wr(PORT_STAT, 8'(d));
        repeat (TRACKS_DEF + 3) port_wr(PORT_SECT, P9_STEP_IN);
        port_rd(PORT_STAT);
        port_rd(PORT_DATA);
        repeat (TRACKS_DEF + 3)
            port_wr(PORT_SECT, $urandom_range(0, 7) == 0 ? P9_STEP_IN | P9_STEP_OUT
                                                         : P9_STEP_OUT);
        port_rd(PORT_STAT);
    endtask

    function automatic int pick_track();
        return ($urandom_range(0, 19) == 0) ? TRACKS_DEF - 1 : $urandom_range(0, 3);
    endfunction

    // Result side: hold ready low for random stretches.
    initial begin
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!no_idle) stall = pick_gap();
            end
        end
    end

    initial begin
        bit drained;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_READ;
        in_ch.port = '0;
        in_ch.byte_value = '0;
        in_ch.drive = '0;
        in_ch.image_address = '0;
        i_rst_n = 1'b0;
        no_idle = 0;
        drained = 0;
        n_items = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reads with nothing selected, then a read and a write on an unknown port.
        issue(CMD_READ, PORT_STAT, 8'h00, 4'h0, 19'h0);
        issue(CMD_READ, PORT_SECT, 8'h00, 4'h0, 19'h0);
        issue(CMD_READ, PORT_DATA, 8'h00, 4'h0, 19'h0);
        issue(CMD_READ, 8'hFF, 8'h00, 4'h0, 19'h0);
        issue(CMD_WRITE, 8'h00, 8'hFF, 4'h0, 19'h0);
        // Drive beyond range: zero fill sets every buffer byte to a known value.
        issue(CMD_WRITE, PORT_STAT, 8'h0F, 4'h0, 19'h0);
        issue(CMD_READ, PORT_DATA, 8'h00, 4'h0, 19'h0);
        issue(CMD_WRITE, PORT_SECT, P9_STEP_IN | P9_HEAD_LOAD, 4'h0, 19'h0);
        issue(CMD_READ, PORT_SECT, 8'h00, 4'h0, 19'h0);
        issue(CMD_READ, PORT_STAT, 8'h00, 4'h0, 19'h0);
        // Short write on an unmounted drive, then flush it.
        issue(CMD_WRITE, PORT_SECT, P9_WRITE, 4'h0, 19'h0);
        issue(CMD_WRITE, PORT_DATA, 8'hFF, 4'h0, 19'h0);
        issue(CMD_READ, PORT_SECT, 8'h00, 4'h0, 19'h0);
        issue(CMD_SPARE_FIRST, PORT_STAT, 8'h00, 4'h0, 19'h0);
        issue(CMD_SPARE_LAST, 8'hFF, 8'hFF, 4'hF, 19'h7FFFF);
        // Ignored mount and loads, then the last byte of an image.
        issue(CMD_MOUNT, 8'h00, 8'h00, 4'hF, 19'h0);
        issue(CMD_LOAD, 8'h00, 8'hFF, 4'h3, 19'(IMAGE_SIZE));
        issue(CMD_LOAD, 8'h00, 8'hFF, 4'hF, 19'h7FFFF);
        issue(CMD_LOAD, 8'h00, 8'hAA, 4'h0, 19'(IMAGE_SIZE - 1));
        // Unmount the selected drive, deselect, flush with nothing pending.
        issue(CMD_MOUNT, 8'h00, 8'h00, 4'h2, 19'h0);
        issue(CMD_WRITE, PORT_STAT, 8'h02, 4'h0, 19'h0);
        issue(CMD_UNMOUNT, 8'h00, 8'h00, 4'h2, 19'h0);
        issue(CMD_READ, PORT_STAT, 8'h00, 4'h0, 19'h0);
        issue(CMD_WRITE, PORT_STAT, SEL_DESELECT, 4'h0, 19'h0);
        issue(CMD_READ, PORT_SECT, 8'h00, 4'h0, 19'h0);

        clamp_run();
        while (n_items < 1100) begin
            if ($urandom_range(0, 3) == 0) no_idle = !no_idle;
            // Once, halt the sender until every result has drained.
            if (!drained && n_items > 550) begin
                drained = 1;
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: repeat ($urandom_range(1, 8)) noise_item();
                4, 5:       write_sector($urandom_range(0, DRIVES_DEF - 1), pick_track(),
                                         $urandom_range(0, 3));
                6, 7:       read_sector($urandom_range(0, DRIVES_DEF - 1), pick_track(),
                                        $urandom_range(0, 3));
                8:          drive_cmd(CMD_UNMOUNT, 4'($urandom));
                default:    read_sector($urandom_range(0, DRIVES_DEF - 1), 0,
                                        $urandom_range(0, SECTORS - 1));
            endcase
        end
        in_ch.valid <= 1'b0;

        // Drain, then let the block settle before the verdict.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("floppy_disk_controller_ports: match");
        end else begin
            $display("floppy_disk_controller_ports: mismatch");
        end
        $finish;
    end

    // Hard stop if the handshakes hang.
    initial begin
        #50_000_000;
        $display("floppy_disk_controller_ports: mismatch");
        $finish;
    end
endmodule
